// ----- rtl/zics_pkg.sv -----
package zics_pkg;

	localparam int IDX_W   = 10;
	localparam int CUM_W   = 33;
	localparam int UNI_W   = 32;
	localparam int CNT_W   = 11;
	localparam int RANK_W  = 11;

	localparam logic [CNT_W-1:0] USED_RESET = 11'd1024;

	// command queue between front and back, depth kept a power of two
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SAMPLE,
		OP_REDRAW
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] index;
		logic [CUM_W-1:0] value;
	} cmd_t;

endpackage

// ----- rtl/zics_if.sv -----
interface zics_in_if
	import zics_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [IDX_W-1:0] entry_index;
	logic [CUM_W-1:0] cumulative_value;
	logic [UNI_W-1:0] uniform_value;

	modport source (output valid, mode, entry_index, cumulative_value, uniform_value,
		input ready);
	modport sink (input valid, mode, entry_index, cumulative_value, uniform_value,
		output ready);
endinterface

interface zics_out_if
	import zics_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank;
	logic              redraw;

	modport source (output valid, rank, redraw, input ready);
	modport sink (input valid, rank, redraw, output ready);
endinterface

interface zics_cfg_if
	import zics_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/zipf_inverse_cdf_sampler_top.sv -----
// Zipf rank sampler by inverse CDF. A load item (mode 0) writes one cumulative
// entry into the table and returns nothing; a load at or past MAX_RANKS is dropped.
// A sample item (mode 1) returns one result: the rank (1..clamped used_count) of the first
// entry at or above the uniform value, or redraw with rank 0 for a zero value.
// Items pass through a two-entry command queue, so input is taken while the search
// engine is busy. A sample occupies the engine for a start step, a set-up step,
// then one probe per cycle of the single-read-port table. Loads and redraws do not
// enter the search. The user is to write used_count over cfg only while idle;
// the block itself does not enforce it.
module zipf_inverse_cdf_sampler_top
	import zics_pkg::*;
#(
	parameter int MAX_RANKS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	zics_in_if.sink    req,
	zics_out_if.source rsp,
	zics_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAX_RANKS);

	logic          push_valid;
	logic          push_ready;
	cmd_t          push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	cmd_t          pop_cmd;
	logic [AW-1:0] last_index;

	zics_front #(
		.MAX_RANKS (MAX_RANKS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.last_index (last_index)
	);

	zics_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_cmd    (push_cmd),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_cmd   (pop_cmd)
	);

	zics_back #(
		.MAX_RANKS (MAX_RANKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_cmd),
		.last_index (last_index),
		.rsp        (rsp)
	);

endmodule

// ----- rtl/zics_ram.sv -----
module zics_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/zics_queue.sv -----
module zics_queue
	import zics_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               push;
	logic               pop;

	assign in_ready  = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_PTR_W+1)'(Q_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/zics_front.sv -----
module zics_front
	import zics_pkg::*;
#(
	parameter int MAX_RANKS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	zics_in_if.sink                      req,
	zics_cfg_if.sink                     cfg,
	output logic                         push_valid,
	input  logic                         push_ready,
	output cmd_t                         push_cmd,
	output logic [$clog2(MAX_RANKS)-1:0] last_index
);

	localparam int AW = $clog2(MAX_RANKS);

	logic [CNT_W-1:0] used_q;
	logic             drop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_RESET;
		end else if (cfg.valid) begin
			used_q <= cfg.data;
		end
	end

	// clamp the rank count into 1..MAX_RANKS, keep the index of the last entry
	always_comb begin
		if (used_q == '0) begin
			last_index = '0;
		end else if (32'(used_q) > 32'(MAX_RANKS)) begin
			last_index = AW'(MAX_RANKS - 1);
		end else begin
			last_index = AW'(used_q - 1'b1);
		end
	end

	always_comb begin
		drop           = 1'b0;
		push_cmd.index = req.entry_index;
		if (!req.mode) begin
			push_cmd.op    = OP_LOAD;
			push_cmd.value = req.cumulative_value;
			drop           = !(32'(req.entry_index) < 32'(MAX_RANKS));
		end else if (req.uniform_value == '0) begin
			push_cmd.op    = OP_REDRAW;
			push_cmd.value = '0;
		end else begin
			push_cmd.op    = OP_SAMPLE;
			push_cmd.value = {1'b0, req.uniform_value};
		end
	end

	// out-of-range loads are taken and dropped here
	assign req.ready  = push_ready;
	assign push_valid = req.valid && !drop;

endmodule

// ----- rtl/zics_back.sv -----
module zics_back
	import zics_pkg::*;
#(
	parameter int MAX_RANKS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  cmd_t                         cmd,
	input  logic [$clog2(MAX_RANKS)-1:0] last_index,
	zics_out_if.source                   rsp
);

	localparam int AW = $clog2(MAX_RANKS);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic              state_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	logic [AW-1:0]     mid_q;
	logic [UNI_W-1:0]  u_q;
	logic              pend_q;
	logic              out_valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              redraw_q;

	logic              out_free;
	logic              take;
	logic              ram_we;
	logic [CUM_W-1:0]  ram_rdata;
	logic              at_least;
	logic [AW-1:0]     lo_n;
	logic [AW-1:0]     hi_n;
	logic [AW:0]       sum_n;
	logic [AW-1:0]     mid_n;
	logic              issue;
	logic              done;
	logic              out_set;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == ST_IDLE) && ((cmd.op == OP_LOAD) || out_free);
	assign take      = cmd_valid && cmd_ready;
	assign ram_we    = take && (cmd.op == OP_LOAD);

	// one probe per cycle: compare the returned entry, narrow, issue the next read
	assign at_least = (ram_rdata >= {1'b0, u_q});
	assign lo_n     = (pend_q && !at_least) ? mid_q + 1'b1 : lo_q;
	assign hi_n     = (pend_q && at_least) ? mid_q : hi_q;
	assign sum_n    = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n    = sum_n[AW:1];
	assign issue    = (state_q == ST_SEARCH) && (hi_n > lo_n);
	assign done     = (state_q == ST_SEARCH) && !(hi_n > lo_n);
	assign out_set  = done || (take && (cmd.op == OP_REDRAW));

	zics_ram #(
		.WIDTH (CUM_W),
		.DEPTH (MAX_RANKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(cmd.index)),
		.wdata (cmd.value),
		.re    (issue),
		.raddr (mid_n),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end else if (take && (cmd.op == OP_SAMPLE)) begin
			lo_q <= '0;
			hi_q <= last_index;
			u_q  <= cmd.value[UNI_W-1:0];
		end
		if (done) begin
			rank_q   <= RANK_W'({1'b0, hi_n} + (AW+1)'(1));
			redraw_q <= 1'b0;
		end else if (take && (cmd.op == OP_REDRAW)) begin
			rank_q   <= '0;
			redraw_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving this edge
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (take && (cmd.op == OP_SAMPLE)) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					pend_q <= issue;
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.rank   = rank_q;
	assign rsp.redraw = redraw_q;

`ifndef SYNTHESIS
	a_search_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !out_valid_q)
		else $error("search running while a result is still held");
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");
	a_rank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !redraw_q) |-> (rank_q != '0))
		else $error("sample result with rank zero");
	a_no_take_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> !cmd_ready)
		else $error("command taken during a search");
`endif

endmodule
